>>> hdl/lldp_pkg.sv
package lldp_pkg;

  localparam int unsigned OUI_BYTES = 3;

  // Parser phases
  localparam logic [2:0] PH_SKIP = 3'd0;
  localparam logic [2:0] PH_HDR0 = 3'd1;
  localparam logic [2:0] PH_HDR1 = 3'd2;
  localparam logic [2:0] PH_OUI  = 3'd3;
  localparam logic [2:0] PH_SUB  = 3'd4;
  localparam logic [2:0] PH_VAL  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  // Byte roles
  localparam logic [2:0] ROLE_LINK = 3'd0;
  localparam logic [2:0] ROLE_HDR  = 3'd1;
  localparam logic [2:0] ROLE_OUI  = 3'd2;
  localparam logic [2:0] ROLE_SUB  = 3'd3;
  localparam logic [2:0] ROLE_VAL  = 3'd4;
  localparam logic [2:0] ROLE_IGN  = 3'd5;

  localparam logic [6:0] TLV_TYPE_END     = 7'd0;
  localparam logic [6:0] TLV_TYPE_PRIVATE = 7'd127;

  localparam logic [6:0] HDR_LEN_RESET = 7'd14;
  localparam logic [8:0] PRIV_OVERHEAD = 9'(OUI_BYTES + 1);

  typedef struct packed {
    logic [2:0]  phase;
    logic [6:0]  byte_count;
    logic [7:0]  header_high;
    logic [6:0]  cur_type;
    logic [8:0]  cur_length;
    logic [8:0]  offset_count;
    logic [23:0] oui;
    logic [7:0]  subtype;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:        PH_SKIP,
    byte_count:   7'd0,
    header_high:  8'd0,
    cur_type:     7'd0,
    cur_length:   9'd0,
    offset_count: 9'd0,
    oui:          24'd0,
    subtype:      8'd0
  };

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [6:0]  tlv_type;
    logic [8:0]  value_length;
    logic [8:0]  value_offset;
    logic [23:0] org_id;
    logic [7:0]  org_subtype;
    logic        tlv_last;
    logic        frame_done;
    logic        malformed;
  } result_t;

endpackage

>>> hdl/lldp_tlv_deframer.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  data_byte_i, frame_last_i
// output    out        out_valid_o/out_stall_i byte_out_o .. malformed_o
// config    in         cfg_we_i               cfg_data_i (header_length)
//
// One result per input byte, one byte per cycle while out_stall_i is low;
// the single result register after the per-byte parser holds each result.
// A request is taken while the result register is empty or being drained.
// Reset empties the result register, restores header_length to 14 and
// returns the parser to the link header skip.
// A stall on the output holds the result and stalls the input in turn.
module lldp_tlv_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  byte_role_o,
  output logic [6:0]  tlv_type_o,
  output logic [8:0]  value_length_o,
  output logic [8:0]  value_offset_o,
  output logic [23:0] org_id_o,
  output logic [7:0]  org_subtype_o,
  output logic        tlv_last_o,
  output logic        frame_done_o,
  output logic        malformed_o
);
  import lldp_pkg::*;

  logic [6:0] hdr_len_q;
  state_t     state_q, state_d;
  result_t    res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  lldp_parse u_parse (
    .state_i        (state_q),
    .data_byte_i    (data_byte_i),
    .frame_last_i   (frame_last_i),
    .header_length_i(hdr_len_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q   <= HDR_LEN_RESET;
      state_q     <= STATE_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hdr_len_q <= cfg_data_i;
      end
      if (accept) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = res_q.byte_out;
  assign byte_role_o    = res_q.byte_role;
  assign tlv_type_o     = res_q.tlv_type;
  assign value_length_o = res_q.value_length;
  assign value_offset_o = res_q.value_offset;
  assign org_id_o       = res_q.org_id;
  assign org_subtype_o  = res_q.org_subtype;
  assign tlv_last_o     = res_q.tlv_last;
  assign frame_done_o   = res_q.frame_done;
  assign malformed_o    = res_q.malformed;

endmodule

>>> hdl/lldp_parse.sv
module lldp_parse (
  input  lldp_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_last_i,
  input  logic [6:0]        header_length_i,
  output lldp_pkg::state_t  state_o,
  output lldp_pkg::result_t result_o
);
  import lldp_pkg::*;

  logic [2:0]  phase;
  logic [8:0]  len;
  logic [6:0]  htype;
  logic [9:0]  off_inc;
  logic [23:0] oui_next;
  logic [6:0]  cnt_inc;
  state_t      nxt;
  result_t     res;

  always_comb begin
    nxt      = state_i;
    res      = '0;
    len      = {state_i.header_high[0], data_byte_i};
    htype    = state_i.header_high[7:1];
    off_inc  = {1'b0, state_i.offset_count} + 10'd1;
    oui_next = {state_i.oui[15:0], data_byte_i};
    cnt_inc  = state_i.byte_count + 7'd1;

    res.byte_out = data_byte_i;

    // header length is compared live, so a late rewrite takes effect at once
    phase = state_i.phase;
    if (phase == PH_SKIP && state_i.byte_count >= header_length_i) begin
      phase = PH_HDR0;
    end

    unique case (phase)
      PH_SKIP: begin
        nxt.byte_count = cnt_inc;
        res.byte_role  = ROLE_LINK;
      end
      PH_HDR0: begin
        nxt.header_high  = data_byte_i;
        nxt.cur_type     = data_byte_i[7:1];
        nxt.cur_length   = '0;
        nxt.offset_count = '0;
        nxt.oui          = '0;
        nxt.subtype      = '0;
        nxt.byte_count   = '0;
        nxt.phase        = PH_HDR1;
        res.byte_role    = ROLE_HDR;
        res.tlv_type     = data_byte_i[7:1];
        res.malformed    = frame_last_i;
      end
      PH_HDR1: begin
        nxt.cur_type  = htype;
        res.byte_role = ROLE_HDR;
        if (htype == TLV_TYPE_END) begin
          nxt.cur_length = len;
          nxt.phase      = PH_DONE;
          res.tlv_last   = 1'b1;
          res.frame_done = 1'b1;
        end else if (htype == TLV_TYPE_PRIVATE && len >= PRIV_OVERHEAD) begin
          nxt.cur_length = len - PRIV_OVERHEAD;
          nxt.byte_count = '0;
          nxt.phase      = PH_OUI;
        end else begin
          nxt.cur_length = len;
          if (len == '0) begin
            res.tlv_last = 1'b1;
            nxt.phase    = PH_HDR0;
          end else begin
            nxt.offset_count = '0;
            nxt.phase        = PH_VAL;
          end
        end
        res.tlv_type     = htype;
        res.value_length = nxt.cur_length;
        res.malformed    = frame_last_i & ~res.tlv_last;
      end
      PH_OUI: begin
        nxt.oui          = oui_next;
        nxt.byte_count   = cnt_inc;
        res.byte_role    = ROLE_OUI;
        res.tlv_type     = state_i.cur_type;
        res.value_length = state_i.cur_length;
        res.org_id       = oui_next;
        if (cnt_inc >= 7'(OUI_BYTES)) begin
          nxt.byte_count = '0;
          nxt.phase      = PH_SUB;
        end
        res.malformed = frame_last_i;
      end
      PH_SUB: begin
        nxt.subtype      = data_byte_i;
        res.byte_role    = ROLE_SUB;
        res.tlv_type     = state_i.cur_type;
        res.value_length = state_i.cur_length;
        res.org_id       = state_i.oui;
        res.org_subtype  = data_byte_i;
        if (state_i.cur_length == '0) begin
          res.tlv_last = 1'b1;
          nxt.phase    = PH_HDR0;
        end else begin
          nxt.offset_count = '0;
          nxt.phase        = PH_VAL;
        end
        res.malformed = frame_last_i & ~res.tlv_last;
      end
      PH_VAL: begin
        res.byte_role    = ROLE_VAL;
        res.tlv_type     = state_i.cur_type;
        res.value_length = state_i.cur_length;
        res.value_offset = state_i.offset_count;
        res.org_id       = state_i.oui;
        res.org_subtype  = state_i.subtype;
        if (off_inc >= {1'b0, state_i.cur_length}) begin
          res.tlv_last = 1'b1;
          nxt.phase    = PH_HDR0;
        end
        nxt.offset_count = off_inc[8:0];
        res.malformed    = frame_last_i & ~res.tlv_last;
      end
      default: begin
        res.byte_role  = ROLE_IGN;
        res.frame_done = 1'b1;
        nxt.phase      = PH_DONE;
      end
    endcase

    if (frame_last_i) begin
      res.frame_done = 1'b1;
      nxt            = STATE_CLEAR;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

>>> hdl/lldp_checker.sv
module lldp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  byte_out_o,
  input logic [2:0]  byte_role_o,
  input logic [6:0]  tlv_type_o,
  input logic [8:0]  value_offset_o,
  input logic [23:0] org_id_o,
  input logic        frame_done_o,
  input logic        malformed_o
);
  import lldp_pkg::*;

  // an empty result register must never hold off the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // a stalled result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o)
      && $stable(byte_role_o))
    else $error("stalled result changed");

  // malformed only ever reported on the frame's last byte
  a_mal_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && malformed_o |-> frame_done_o)
    else $error("malformed without frame_done");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o != ROLE_VAL |-> value_offset_o == 9'd0)
    else $error("value_offset set on non-value byte");

  a_no_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_role_o == ROLE_LINK || byte_role_o == ROLE_IGN)
      |-> tlv_type_o == 7'd0 && org_id_o == 24'd0)
    else $error("TLV context shown outside a TLV");

endmodule

bind lldp_tlv_deframer lldp_checker u_lldp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .byte_out_o    (byte_out_o),
  .byte_role_o   (byte_role_o),
  .tlv_type_o    (tlv_type_o),
  .value_offset_o(value_offset_o),
  .org_id_o      (org_id_o),
  .frame_done_o  (frame_done_o),
  .malformed_o   (malformed_o)
);
